// ===== sv/hpg_pkg.sv =====
// Shared types and constants of the Halton point generator.
package hpg_pkg;

  localparam int IndexW = 32;
  localparam int CoordW = 32;
  localparam int BaseW  = 6;
  localparam int DimW   = 3;
  localparam int NumBaseRegs = 6;

  // Wide enough for the mirrored digits and for base^digits (below 2^38).
  localparam int AccW = 38;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegDimCount = 3'd0;
  localparam logic [2:0] RegBase0    = 3'd1;

  typedef logic [BaseW-1:0] base_t;

  localparam base_t BaseReset [NumBaseRegs] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13
  };

  // Request to the radical inverse unit.
  typedef struct packed {
    logic              start;
    logic [IndexW-1:0] index;
    base_t             base;
  } hpg_req_t;

  // Answer of the radical inverse unit.
  typedef struct packed {
    logic              done;
    logic [CoordW-1:0] coord;
  } hpg_rsp_t;

endpackage

// ===== sv/hpg_radinv.sv =====
// Iterative radical inverse unit: digit peeling and fraction division.
module hpg_radinv
  import hpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  hpg_req_t req,
  output hpg_rsp_t rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RECIP = 3'd1;
  localparam logic [2:0] S_MULQ  = 3'd2;
  localparam logic [2:0] S_MULR  = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_FSET  = 3'd5;
  localparam logic [2:0] S_FINAL = 3'd6;

  logic [2:0]        state;
  logic [IndexW-1:0] n;
  base_t             b;
  logic [CoordW-1:0] recip;
  logic [IndexW-1:0] qest;
  logic [6:0]        rem0;
  logic [AccW-1:0]   mirrored;
  logic [AccW-1:0]   scale;

  // Shared restoring divider, one quotient bit a cycle.
  logic [AccW-1:0]   rem;
  logic [AccW-1:0]   dvs;
  logic [CoordW-1:0] quo;
  logic [4:0]        cnt;
  logic [AccW:0]     rem_sh;
  logic [AccW:0]     rem_sub;
  logic              div_ge;
  logic [AccW-1:0]   rem_next;
  logic [CoordW-1:0] quo_next;

  logic              done;
  logic [CoordW-1:0] coord;

  base_t             base_eff;
  logic [63:0]       nprod;
  logic [43:0]       qb;
  logic [IndexW-1:0] ndiff;
  logic              fix_ge;
  logic [6:0]        fix_sub;
  base_t             digit;
  logic [IndexW-1:0] nq;
  logic [43:0]       mprod;
  logic [43:0]       sprod;

  assign rsp.done  = done;
  assign rsp.coord = coord;

  assign base_eff = (req.base < 6'd2) ? 6'd2 : req.base;

  assign rem_sh   = {rem, 1'b0};
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign div_ge   = (rem_sh >= {1'b0, dvs});
  assign rem_next = div_ge ? rem_sub[AccW-1:0] : rem_sh[AccW-1:0];
  assign quo_next = {quo[CoordW-2:0], div_ge};

  // Quotient estimate from the reciprocal; low by at most one.
  assign nprod = {32'd0, n} * {32'd0, recip};
  assign qb    = {12'd0, qest} * {38'd0, b};
  assign ndiff = n - qb[IndexW-1:0];

  assign fix_ge  = (rem0 >= {1'b0, b});
  assign fix_sub = rem0 - {1'b0, b};
  assign digit   = fix_ge ? fix_sub[BaseW-1:0] : rem0[BaseW-1:0];
  assign nq      = qest + {31'd0, fix_ge};
  assign mprod   = {6'd0, mirrored} * {38'd0, b};
  assign sprod   = {6'd0, scale} * {38'd0, b};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            n        <= req.index;
            b        <= base_eff;
            rem      <= AccW'(1);
            dvs      <= {32'd0, base_eff};
            quo      <= '0;
            cnt      <= '0;
            mirrored <= '0;
            scale    <= AccW'(1);
            state    <= S_RECIP;
          end
        end
        S_RECIP: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            recip <= quo_next;
            state <= (n == '0) ? S_FSET : S_MULQ;
          end
        end
        S_MULQ: begin
          qest  <= nprod[63:32];
          state <= S_MULR;
        end
        S_MULR: begin
          rem0  <= ndiff[6:0];
          state <= S_ACC;
        end
        S_ACC: begin
          mirrored <= mprod[AccW-1:0] + {32'd0, digit};
          scale    <= sprod[AccW-1:0];
          n        <= nq;
          state    <= (nq == '0) ? S_FSET : S_MULQ;
        end
        S_FSET: begin
          rem   <= mirrored;
          dvs   <= scale;
          quo   <= '0;
          cnt   <= '0;
          state <= S_FINAL;
        end
        S_FINAL: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            coord <= quo_next;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/halton_point_generator_top.sv =====
// Top level of the Halton point generator: configuration, sequencing and output.
//
// Each accepted input item whose request bit is set produces one Halton point as a
// burst of output items, one per active dimension in ascending order, the last one
// marked with tlast. A coordinate is the radical inverse of the running point index
// in the base held for that dimension (2 for a base below 2), truncated to an
// unsigned 0.32 fraction. The index starts at 1 after reset, rises by one per
// point and wraps from its maximum back to 1; an item with the request bit clear
// is taken and produces nothing. All coordinates come from a single radical
// inverse unit that is used once per dimension. For one coordinate it first
// forms the reciprocal of the base by a 32-step division, then peels one base
// digit per pass of three steps (multiply by the reciprocal, back-multiply,
// correct and accumulate), and finally divides the mirrored digits by
// base^digits in another 32 steps. The block takes no new input item until the
// last coordinate of the current point has been accepted. Configuration writes
// are meant to be made only while the block is idle.
module halton_point_generator_top
  import hpg_pkg::*;
#(
  parameter int MAX_DIMS = 6
) (
  input  logic              clk,
  input  logic              rst,
  // Input items
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [0] request, [7:1] zero
  // Output items
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CoordW-1:0] m_tdata,   // [31:0] coordinate
  output logic [DimW-1:0]   m_tuser,   // [2:0] dim_index
  output logic              m_tlast,   // last_coord
  // Configuration writes
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [BaseW-1:0]  cfg_wdata
);

  localparam int SelW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LAUNCH = 2'd1;
  localparam logic [1:0] S_CALC   = 2'd2;
  localparam logic [1:0] S_SEND   = 2'd3;

  logic [1:0]        state;
  logic [DimW-1:0]   dim_count;
  base_t             base_regs [MAX_DIMS];
  logic [IndexW-1:0] point_index;
  logic [DimW-1:0]   dim;
  logic [DimW-1:0]   last_dim;
  logic [DimW-1:0]   dims_eff;

  hpg_req_t ri_req;
  hpg_rsp_t ri_rsp;

  logic in_fire;
  logic out_fire;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  // A count of zero means one coordinate; counts above the build limit saturate.
  always_comb begin
    if (dim_count == '0) begin
      dims_eff = DimW'(1);
    end else if (dim_count > DimW'(MAX_DIMS)) begin
      dims_eff = DimW'(MAX_DIMS);
    end else begin
      dims_eff = dim_count;
    end
  end

  assign ri_req.start = (state == S_LAUNCH);
  assign ri_req.index = point_index;
  assign ri_req.base  = base_regs[dim[SelW-1:0]];

  hpg_radinv u_radinv (
    .clk (clk),
    .rst (rst),
    .req (ri_req),
    .rsp (ri_rsp)
  );

  // Configuration registers; writes to bases beyond the build limit are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= DimW'(1);
    end else if (cfg_we && (cfg_addr == RegDimCount)) begin
      dim_count <= cfg_wdata[DimW-1:0];
    end
  end

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_base
    always_ff @(posedge clk) begin
      if (rst) begin
        base_regs[k] <= BaseReset[k];
      end else if (cfg_we && (cfg_addr == RegBase0 + 3'(k))) begin
        base_regs[k] <= cfg_wdata;
      end
    end
  end

  // Point sequencer: one coordinate at a time, each held until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      point_index <= IndexW'(1);
      dim         <= '0;
      last_dim    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire && s_tdata[0]) begin
            dim      <= '0;
            last_dim <= dims_eff - DimW'(1);
            state    <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (ri_rsp.done) begin
            m_tdata  <= ri_rsp.coord;
            m_tuser  <= dim;
            m_tlast  <= (dim == last_dim);
            m_tvalid <= 1'b1;
            state    <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_fire) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              point_index <= (point_index == '1) ? IndexW'(1)
                                                 : point_index + IndexW'(1);
              state       <= S_IDLE;
            end else begin
              dim   <= dim + DimW'(1);
              state <= S_LAUNCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_halton_point_generator_top.sv =====
// Self-checking testbench of the Halton point generator, directed table then random phases.
`timescale 1ns / 1ps

module tb_halton_point_generator_top;
  import hpg_pkg::*;

  // The block under test is built with its full number of dimensions.
  localparam int MaxDims = 6;

  // A point costs at most six coordinates plus the receiver's stalls. The
  // limit below is several times the slowest run of about 430 items.
  localparam int CycleLimit = 3_000_000;

  // Cycles left to pass once every coordinate has arrived. This covers an
  // item with the request bit clear, which may still be in flight, and is
  // longer than one full coordinate of the radical inverse unit.
  localparam int SettlePause = 400;

  localparam int RandomPhases   = 7;
  localparam int PointsPerPhase = 50;

  // Register indexes beyond those of the package.
  localparam logic [2:0] RegBase1   = RegBase0 + 3'd1;
  localparam logic [2:0] RegBase2   = RegBase0 + 3'd2;
  localparam logic [2:0] RegBase3   = RegBase0 + 3'd3;
  localparam logic [2:0] RegBase4   = RegBase0 + 3'd4;
  localparam logic [2:0] RegBase5   = RegBase0 + 3'd5;
  localparam logic [2:0] RegUnknown = 3'd7;
  // Filler for the index column of rows that send an item.
  localparam logic [2:0] NoReg      = 3'd0;

  typedef enum logic {RowWrite, RowItem} row_kind_t;

  // One row of the directed table. For an item row the value holds the
  // request bit, and golden_on marks a first coordinate typed in by hand.
  typedef struct packed {
    row_kind_t         kind;
    logic [2:0]        addr;
    logic [BaseW-1:0]  value;
    logic              golden_on;
    logic [CoordW-1:0] golden;
  } row_t;

  localparam int NumRows = 24;

  // The indexes run 1, 2, 3 in base 2 first, so the coordinates are plain
  // binary fractions. Later rows cover the clamping of the dimension count,
  // radix zero and one, radices above the prime table, a composite radix
  // and a write to an index that holds no register.
  localparam row_t DirectedRows [NumRows] = '{
    '{RowItem,  NoReg,       6'd1,  1'b1, 32'h8000_0000},  // index 1
    '{RowItem,  NoReg,       6'd0,  1'b0, 32'h0},          // request clear
    '{RowItem,  NoReg,       6'd1,  1'b1, 32'h4000_0000},  // index 2
    '{RowItem,  NoReg,       6'd1,  1'b1, 32'hC000_0000},  // index 3
    '{RowWrite, RegDimCount, 6'd6,  1'b0, 32'h0},
    '{RowItem,  NoReg,       6'd1,  1'b0, 32'h0},          // six coordinates
    '{RowWrite, RegDimCount, 6'd0,  1'b0, 32'h0},          // zero acts as one
    '{RowItem,  NoReg,       6'd1,  1'b1, 32'hA000_0000},  // index 5
    '{RowWrite, RegDimCount, 6'h3F, 1'b0, 32'h0},          // seven saturates
    '{RowItem,  NoReg,       6'd1,  1'b0, 32'h0},
    '{RowWrite, RegBase0,    6'd0,  1'b0, 32'h0},          // radix zero
    '{RowWrite, RegBase1,    6'd1,  1'b0, 32'h0},          // radix one
    '{RowWrite, RegBase2,    6'd63, 1'b0, 32'h0},
    '{RowWrite, RegBase3,    6'd47, 1'b0, 32'h0},
    '{RowWrite, RegBase4,    6'd4,  1'b0, 32'h0},          // not prime
    '{RowWrite, RegBase5,    6'd42, 1'b0, 32'h0},
    '{RowItem,  NoReg,       6'd1,  1'b1, 32'hE000_0000},  // index 7, radix 2
    '{RowItem,  NoReg,       6'd0,  1'b0, 32'h0},
    '{RowItem,  NoReg,       6'd1,  1'b0, 32'h0},
    '{RowWrite, RegUnknown,  6'h3F, 1'b0, 32'h0},          // must be ignored
    '{RowItem,  NoReg,       6'd1,  1'b0, 32'h0},
    '{RowWrite, RegDimCount, 6'h3B, 1'b0, 32'h0},          // low bits give 3
    '{RowItem,  NoReg,       6'd1,  1'b0, 32'h0},
    '{RowItem,  NoReg,       6'd1,  1'b0, 32'h0}
  };

  // One expected output item.
  typedef struct {
    logic [DimW-1:0]   dim;
    logic [CoordW-1:0] coord;
    logic              last;
  } coord_item_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = 8'h00;   // [0] request, [7:1] zero
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [CoordW-1:0] m_tdata;             // [31:0] coordinate
  logic [DimW-1:0]   m_tuser;             // [2:0] dim_index
  logic              m_tlast;
  logic              cfg_we    = 1'b0;
  logic [2:0]        cfg_addr  = 3'd0;
  logic [BaseW-1:0]  cfg_wdata = '0;

  // The predictor's own copy of the registers and of the running index.
  logic [IndexW-1:0] point_idx;
  logic [2:0]        dims_reg;
  base_t             radix_reg [NumBaseRegs];

  // Coordinates predicted but not yet seen on the output, oldest first.
  coord_item_t pending_coords [$];

  int errors       = 0;
  int points_sent  = 0;
  int empty_sent   = 0;
  int coords_seen  = 0;
  int writes_made  = 0;
  int cycles       = 0;
  int src_quiet    = 0;
  int sink_quiet   = 0;

  halton_point_generator_top #(
    .MAX_DIMS(MaxDims)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact floor(2^32 * inverse): the base-b digits of the index are
  // reversed into an integer, which is then divided by b^digits bit by bit.
  function automatic logic [CoordW-1:0] halton_coord(input logic [IndexW-1:0] idx,
                                                     input base_t radix);
    logic [63:0]       b;
    logic [63:0]       mirrored;
    logic [63:0]       scale;
    logic [63:0]       rem;
    logic [IndexW-1:0] n;
    logic [CoordW-1:0] q;
    b = (radix < 2) ? 64'd2 : {58'd0, radix};
    n = idx;
    mirrored = '0;
    scale = 64'd1;
    while (n != 0) begin
      mirrored = mirrored * b + (n % b);
      scale = scale * b;
      n = IndexW'(n / b);
    end
    rem = mirrored;
    q = '0;
    for (int k = 0; k < CoordW; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= scale) begin
        rem = rem - scale;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Queues the coordinates of one accepted request and moves the index on.
  function automatic void predict_point(input logic req, input logic golden_on,
                                        input logic [CoordW-1:0] golden);
    int dims;
    coord_item_t e;
    if (!req) begin
      empty_sent++;
      return;
    end
    dims = (dims_reg == 0) ? 1 : ((dims_reg > MaxDims) ? MaxDims : int'(dims_reg));
    for (int d = 0; d < dims; d++) begin
      e.dim = d[DimW-1:0];
      e.coord = (d == 0 && golden_on) ? golden : halton_coord(point_idx, radix_reg[d]);
      e.last = (d == dims - 1);
      pending_coords.push_back(e);
    end
    point_idx = (point_idx == '1) ? IndexW'(1) : point_idx + 1'b1;
    points_sent++;
  endfunction

  // Idle cycles before the next item on either side, with occasional
  // stretches in which that side does not idle at all.
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(8, 30);
    end
    return $urandom_range(0, 12);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // A write takes effect at the next rising edge. The enable is left high
  // so that writes can follow back to back; sending an item lowers it.
  task automatic cfg_write(input logic [2:0] addr, input logic [BaseW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    if (addr == RegDimCount) begin
      dims_reg = value[2:0];
    end else if (addr >= RegBase0 && addr < RegBase0 + NumBaseRegs) begin
      radix_reg[addr - RegBase0] = value;
    end
    writes_made++;
  endtask

  // Offers one item after a random gap and waits for it to be taken.
  task automatic send_item(input logic req, input logic golden_on,
                           input logic [CoordW-1:0] golden);
    int gap;
    gap = draw_wait(src_quiet);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, req};
    do @(posedge clk); while (!s_tready);
    predict_point(req, golden_on, golden);
  endtask

  // Brings the block to rest: no item offered, every coordinate seen, and
  // then a pause long enough for an item that produces nothing.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (SettlePause) @(posedge clk);
  endtask

  // Radix choice for random phases, leaning on the edges of the range.
  function automatic base_t pick_radix();
    case ($urandom_range(0, 7))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd2;
      3: return 6'd47;
      4: return 6'd63;
      default: return base_t'($urandom_range(0, 63));
    endcase
  endfunction

  // The receiver stalls for a random number of cycles before each item.
  initial begin : drain
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(sink_quiet);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Every output item taken is compared with the oldest expectation.
  always @(posedge clk) begin : check_output
    coord_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      coords_seen++;
      if (pending_coords.size() == 0) begin
        report_mismatch($sformatf("unexpected item: dim %0d coord %h last %b",
                                  m_tuser, m_tdata, m_tlast));
      end else begin
        want = pending_coords.pop_front();
        if (m_tuser !== want.dim) begin
          report_mismatch($sformatf("dim_index %0d, expected %0d", m_tuser, want.dim));
        end
        if (m_tdata !== want.coord) begin
          report_mismatch($sformatf("dim %0d coordinate %h, expected %h",
                                    want.dim, m_tdata, want.coord));
        end
        if (m_tlast !== want.last) begin
          report_mismatch($sformatf("dim %0d last_coord %b, expected %b",
                                    want.dim, m_tlast, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timed out after %0d cycles with %0d coordinates outstanding",
               cycles, pending_coords.size());
      $display("[halton_point_generator_top] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    int p;
    int sent;
    logic req;
    logic [BaseW-1:0] dims_val;
    base_t radix_val;

    point_idx = IndexW'(1);
    dims_reg  = 3'd1;
    for (int k = 0; k < NumBaseRegs; k++) begin
      radix_reg[k] = BaseReset[k];
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table. A run of write rows is preceded by one settling pause.
    for (r = 0; r < NumRows; r++) begin
      if (DirectedRows[r].kind == RowWrite) begin
        if (r == 0 || DirectedRows[r-1].kind != RowWrite) begin
          settle();
        end
        cfg_write(DirectedRows[r].addr, DirectedRows[r].value);
      end else begin
        send_item(DirectedRows[r].value[0], DirectedRows[r].golden_on,
                  DirectedRows[r].golden);
      end
    end

    // Random phases: every register is rewritten while idle, then a run of
    // requests with a sprinkling of items whose request bit is clear. The
    // first phases pin the extremes: all radices at the top with six
    // dimensions, all at the bottom with one, and all at 47 with six.
    for (p = 0; p < RandomPhases; p++) begin
      settle();
      case (p)
        0: dims_val = 6'd6;
        1: dims_val = 6'd1;
        2: dims_val = 6'd6;
        default: dims_val = BaseW'($urandom_range(0, 63));
      endcase
      cfg_write(RegDimCount, dims_val);
      for (int k = 0; k < NumBaseRegs; k++) begin
        case (p)
          0: radix_val = 6'd63;
          1: radix_val = 6'd2;
          2: radix_val = 6'd47;
          default: radix_val = pick_radix();
        endcase
        cfg_write(RegBase0 + k[2:0], radix_val);
      end
      cfg_write(RegUnknown, BaseW'($urandom_range(0, 63)));

      sent = 0;
      while (sent < PointsPerPhase) begin
        req = ($urandom_range(0, 99) < 85);
        send_item(req, 1'b0, '0);
        if (req) begin
          sent++;
        end
      end
    end

    settle();

    $display("Covered %0d points and %0d empty requests, %0d coordinates checked.",
             points_sent, empty_sent, coords_seen);
    $display("Made %0d register writes over %0d random settings plus the directed table.",
             writes_made, RandomPhases);
    if (errors == 0) begin
      $display("[halton_point_generator_top] OK");
    end else begin
      $display("[halton_point_generator_top] ERROR");
    end
    $finish;
  end

endmodule
